### hdl/prf_pkg.sv
// Package with the shared types and codes of the ring-buffer byte pipe.
package prf_pkg;

	typedef enum logic [1:0] {
		KIND_WRITE    = 2'd0,
		KIND_READ     = 2'd1,
		KIND_CLOSE_WR = 2'd2,
		KIND_CLOSE_RD = 2'd3
	} op_kind_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_WAIT = 2'd1,
		ST_EOD  = 2'd2,
		ST_FAIL = 2'd3
	} status_t;

	typedef struct packed {
		op_kind_t    kind;
		logic [7:0]  write_data;
		logic        request_last;
	} cmd_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  read_data;
		logic [8:0]  fill_level;
		logic        request_done;
	} rsp_t;

	typedef enum logic [1:0] {
		CTRL_IDLE = 2'd0,
		CTRL_EXEC = 2'd1,
		CTRL_RESP = 2'd2
	} ctrl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic execute;
	} dp_ctrl_t;

endpackage

### hdl/prf_ctrl.sv
// Controller state machine of the ring-buffer byte pipe.
module prf_ctrl
	import prf_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	output logic     done,
	output dp_ctrl_t dp_ctrl
);

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CTRL_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d         = state_q;
		busy            = 1'b0;
		done            = 1'b0;
		dp_ctrl.capture = 1'b0;
		dp_ctrl.execute = 1'b0;
		case (state_q)
			CTRL_IDLE: begin
				dp_ctrl.capture = start;
				if (start) begin
					state_d = CTRL_EXEC;
				end
			end
			CTRL_EXEC: begin
				busy            = 1'b1;
				dp_ctrl.execute = 1'b1;
				state_d         = CTRL_RESP;
			end
			CTRL_RESP: begin
				// The result shows while the next command is taken in.
				done            = 1'b1;
				dp_ctrl.capture = start;
				state_d         = start ? CTRL_EXEC : CTRL_IDLE;
			end
			default: begin
				state_d = CTRL_IDLE;
			end
		endcase
	end

endmodule

### hdl/prf_dp.sv
// Datapath of the ring-buffer byte pipe: byte memory, indices and end flags.
module prf_dp
	import prf_pkg::*;
#(
	parameter int DEPTH = 512
)
(
	input  logic     clk,
	input  logic     arst_n,
	input  dp_ctrl_t dp_ctrl,
	input  cmd_t     cmd,
	output rsp_t     rsp
);

	localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FILL_W = PTR_W + 1;

	logic [7:0]       mem [DEPTH];
	cmd_t             cmd_q;
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic             writer_open_q;
	logic             reader_open_q;
	status_t          status_q;
	logic             rd_ok_q;
	logic             last_q;
	logic [7:0]       rd_data_q;

	logic [PTR_W-1:0]  head_next;
	logic [PTR_W-1:0]  tail_next;
	logic              empty;
	logic              full;
	logic              wr_en;
	logic              rd_en;
	status_t           status_d;
	logic [FILL_W-1:0] fill;
	logic [31:0]       fill_ext;

	assign head_next = (head_q == PTR_W'(DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign tail_next = (tail_q == PTR_W'(DEPTH - 1)) ? '0 : tail_q + 1'b1;
	assign empty     = (head_q == tail_q);
	assign full      = (tail_next == head_q);

	always_comb begin
		status_d = ST_OK;
		wr_en    = 1'b0;
		rd_en    = 1'b0;
		case (cmd_q.kind)
			KIND_WRITE: begin
				if (!writer_open_q || !reader_open_q) begin
					status_d = ST_FAIL;
				end else if (full) begin
					status_d = ST_WAIT;
				end else begin
					wr_en = dp_ctrl.execute;
				end
			end
			KIND_READ: begin
				if (!reader_open_q) begin
					status_d = ST_FAIL;
				end else if (empty) begin
					status_d = writer_open_q ? ST_WAIT : ST_EOD;
				end else begin
					rd_en = dp_ctrl.execute;
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[tail_q] <= cmd_q.write_data;
		end
		if (dp_ctrl.execute) begin
			rd_data_q <= mem[head_q];
		end
	end

	always_ff @(posedge clk) begin
		if (dp_ctrl.capture) begin
			cmd_q <= cmd;
		end
		if (dp_ctrl.execute) begin
			status_q <= status_d;
			rd_ok_q  <= rd_en;
			last_q   <= cmd_q.request_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q        <= '0;
			tail_q        <= '0;
			writer_open_q <= 1'b1;
			reader_open_q <= 1'b1;
		end else if (dp_ctrl.execute) begin
			if (wr_en) begin
				tail_q <= tail_next;
			end
			if (rd_en) begin
				head_q <= head_next;
			end
			if (cmd_q.kind == KIND_CLOSE_WR) begin
				writer_open_q <= 1'b0;
			end
			if (cmd_q.kind == KIND_CLOSE_RD) begin
				reader_open_q <= 1'b0;
			end
		end
	end

	// Occupancy from the indices; they are stable while the result is shown.
	assign fill = (tail_q >= head_q) ?
		({1'b0, tail_q} - {1'b0, head_q}) :
		({1'b0, tail_q} + FILL_W'(DEPTH) - {1'b0, head_q});
	assign fill_ext = 32'(fill);

	assign rsp.status       = status_q;
	assign rsp.read_data    = rd_ok_q ? rd_data_q : 8'd0;
	assign rsp.fill_level   = fill_ext[8:0];
	assign rsp.request_done = last_q;

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(head_q) < DEPTH) && (32'(tail_q) < DEPTH))
		else $error("ring index out of range");

	a_no_write_closed: assert property (@(posedge clk) disable iff (!arst_n)
		(dp_ctrl.execute && cmd_q.kind == KIND_WRITE && (!writer_open_q || !reader_open_q))
		|=> (tail_q == $past(tail_q)))
		else $error("write advanced tail with an end closed");

	a_no_read_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(dp_ctrl.execute && empty) |=> (head_q == $past(head_q)))
		else $error("head advanced on an empty buffer");

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		(dp_ctrl.execute && full) |=> (tail_q == $past(tail_q)))
		else $error("tail advanced on a full buffer");

endmodule

### hdl/pipe_ring_fifo_core.sv
// Top level of the ring-buffer byte pipe: controller plus datapath.
//
// The block is a byte pipe held in a ring buffer of DEPTH slots; one slot
// always stays free, so at most DEPTH-1 bytes are held. Each command is one
// operation: write a byte, read a byte, close the writer end or close the
// reader end. A command transfer happens at a rising edge with start high
// and busy low. Every command gives exactly one result, shown on rsp for a
// single cycle while done is high; the receiver must take it in that cycle,
// since it cannot hold results off.
// The command is registered at its transfer and evaluated in the execute
// state, where status and read byte are registered; then done is high.
// A command may be issued in the very cycle a result is shown, but none is
// taken while busy is high. The registered read port of the byte memory
// takes the byte at the head index together with the status of the command.
// Reset clears both indices (empty buffer) and reopens both ends. The byte
// memory is not cleared; only slots that were written are ever read back.
// Statuses: ok, wait and retry (full on write, empty with writer open on
// read), end of data (empty with writer closed), failure on a closed end.
module pipe_ring_fifo_core
	import prf_pkg::*;
#(
	parameter int DEPTH = 512
)
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  cmd_t cmd,
	output logic busy,
	output logic done,
	output rsp_t rsp
);

	dp_ctrl_t dp_ctrl;

	// Sequencer: capture, evaluate, present the result.
	prf_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.done    (done),
		.dp_ctrl (dp_ctrl)
	);

	// Storage, index arithmetic and status decisions.
	prf_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.dp_ctrl (dp_ctrl),
		.cmd     (cmd),
		.rsp     (rsp)
	);

endmodule

### bench/tb.sv
// Self-checking testbench for the ring-buffer byte pipe core.
`timescale 1ns / 1ps

module tb;
	import prf_pkg::*;

	localparam int DEPTH = 512;
	// Delay from the command transfer to the result; wait_pipe_idle adds margin.
	localparam int LATENCY = 2;
	localparam int CYCLE_LIMIT = 400000;
	// Each sender phase lasts this many command transfers.
	localparam int PHASE_LEN = 150;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	cmd_t cmd = '0;
	logic busy;
	logic done;
	rsp_t rsp;

	pipe_ring_fifo_core #(.DEPTH(DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.cmd(cmd),
		.busy(busy),
		.done(done),
		.rsp(rsp)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Commands waiting to be driven, and results the pipe still owes us.
	cmd_t cmd_backlog[$];
	rsp_t awaited_rsp[$];

	// Shadow copy of the pipe: byte ring, both indices and both end flags.
	logic [7:0] ring_bytes [DEPTH];
	int ring_head = 0;
	int ring_tail = 0;
	bit wr_open = 1'b1;
	bit rd_open = 1'b1;

	// Bookkeeping for the run summary and the verdict.
	int error_cnt = 0;
	int sent_cnt = 0;
	int xfer_cnt = 0;
	int checked_cnt = 0;
	int status_seen [4];
	int kind_seen [4];
	int fill_peak = 0;
	int cycle_cnt = 0;
	logic took = 1'b0;

	// Percent of free slots in which the sender holds off, by phase. The
	// third phase would be a receiver stall, which this interface cannot
	// express, so the sender runs freely there as in the first phase.
	int idle_pct [4] = '{0, 53, 0, 31};

	function automatic int held_bytes();
		return (ring_tail + DEPTH - ring_head) % DEPTH;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		error_cnt++;
	endtask

	// Applies one command to the shadow pipe and works out its result.
	task automatic predict_pipe_result(input cmd_t c, output rsp_t r);
		r = '0;
		r.status = ST_OK;
		r.request_done = c.request_last;
		case (c.kind)
			KIND_WRITE: begin
				if (!wr_open || !rd_open) begin
					r.status = ST_FAIL;
				end else if ((ring_tail + 1) % DEPTH == ring_head) begin
					r.status = ST_WAIT;
				end else begin
					ring_bytes[ring_tail] = c.write_data;
					ring_tail = (ring_tail + 1) % DEPTH;
				end
			end
			KIND_READ: begin
				if (!rd_open) begin
					r.status = ST_FAIL;
				end else if (ring_head == ring_tail) begin
					// Empty: retry while a writer may still come, else end of data.
					r.status = wr_open ? ST_WAIT : ST_EOD;
				end else begin
					r.read_data = ring_bytes[ring_head];
					ring_head = (ring_head + 1) % DEPTH;
				end
			end
			KIND_CLOSE_WR: begin
				wr_open = 1'b0;
			end
			default: begin
				// Closing the reader keeps the bytes that are held.
				rd_open = 1'b0;
			end
		endcase
		r.fill_level = 9'(held_bytes());
		if (held_bytes() > fill_peak) fill_peak = held_bytes();
	endtask

	// Driver: inputs move only at the falling edge. A new command is put up
	// when the line is free, i.e. nothing was offered or the last offer was
	// taken at the rising edge just passed.
	always @(negedge clk) begin : driver
		logic go;
		cmd_t next;
		if (arst_n && (!start || took)) begin
			go = 1'b0;
			next = cmd;
			if (cmd_backlog.size() > 0 &&
					$urandom_range(99) >= idle_pct[(sent_cnt / PHASE_LEN) % 4]) begin
				go = 1'b1;
				next = cmd_backlog.pop_front();
				sent_cnt++;
			end
			start <= go;
			cmd <= next;
		end
	end

	// Monitor: everything is sampled at the rising edge. A result is checked
	// before the command taken at the same edge is predicted, because that
	// result always belongs to an earlier transfer.
	always @(posedge clk) begin : monitor
		rsp_t want;
		rsp_t pred;
		if (!arst_n) begin
			took <= 1'b0;
		end else begin
			if (done) begin
				if (awaited_rsp.size() == 0) begin
					report_mismatch($sformatf("result with nothing awaited (status %0d)",
						int'(rsp.status)));
				end else begin
					want = awaited_rsp.pop_front();
					checked_cnt++;
					status_seen[int'(rsp.status)]++;
					if (rsp.status !== want.status)
						report_mismatch($sformatf("result %0d status %0d, want %0d",
							checked_cnt, int'(rsp.status), int'(want.status)));
					if (rsp.read_data !== want.read_data)
						report_mismatch($sformatf("result %0d read_data %02h, want %02h",
							checked_cnt, rsp.read_data, want.read_data));
					if (rsp.fill_level !== want.fill_level)
						report_mismatch($sformatf("result %0d fill_level %0d, want %0d",
							checked_cnt, rsp.fill_level, want.fill_level));
					if (rsp.request_done !== want.request_done)
						report_mismatch($sformatf("result %0d request_done %b, want %b",
							checked_cnt, rsp.request_done, want.request_done));
				end
			end
			if (start && !busy) begin
				predict_pipe_result(cmd, pred);
				awaited_rsp.push_back(pred);
				kind_seen[int'(cmd.kind)]++;
				xfer_cnt++;
			end
			took <= start && !busy;
		end
	end

	// Watchdog: a run that stalls ends here with the fail verdict.
	initial begin : watchdog
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("Timeout after %0d cycles, %0d results still awaited",
			cycle_cnt, awaited_rsp.size());
		$display("Regression FAIL");
		$finish;
	end

	task automatic queue_cmd(input op_kind_t k, input logic [7:0] d, input logic last);
		cmd_t c;
		c.kind = k;
		c.write_data = d;
		c.request_last = last;
		cmd_backlog.push_back(c);
	endtask

	// Queues n commands of one kind with random bytes, cut into caller
	// requests of random length; the final byte of each carries the last flag.
	task automatic queue_burst(input op_kind_t k, input int n);
		int left;
		int len;
		left = n;
		while (left > 0) begin
			len = $urandom_range(16, 1);
			if (len > left) len = left;
			for (int i = 0; i < len; i++)
				queue_cmd(k, 8'($urandom), (i == len - 1));
			left -= len;
		end
	endtask

	// Waits until every queued command has been transferred and answered,
	// then lets the pipeline settle.
	task automatic wait_pipe_idle();
		while (cmd_backlog.size() > 0 || start || awaited_rsp.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	initial begin : stimulus
		int mixed;
		int n;
		int guard;
		op_kind_t k;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed opening: read on an empty pipe with the writer open, the
		// byte extremes, a short drain back to empty and a second empty read.
		queue_cmd(KIND_READ, 8'h00, 1'b1);
		queue_cmd(KIND_WRITE, 8'h00, 1'b0);
		queue_cmd(KIND_WRITE, 8'hFF, 1'b0);
		queue_cmd(KIND_WRITE, 8'h5A, 1'b0);
		queue_cmd(KIND_WRITE, 8'hA5, 1'b1);
		queue_cmd(KIND_READ, 8'hFF, 1'b0);
		queue_cmd(KIND_READ, 8'h00, 1'b0);
		queue_cmd(KIND_READ, 8'h00, 1'b0);
		queue_cmd(KIND_READ, 8'h00, 1'b1);
		queue_cmd(KIND_READ, 8'h00, 1'b0);
		queue_cmd(KIND_WRITE, 8'h81, 1'b1);
		queue_cmd(KIND_READ, 8'h7E, 1'b1);
		wait_pipe_idle();

		// Fill the ring to capacity and push a few more so that writes see
		// the full condition, then drain most of it so the indices wrap later.
		queue_burst(KIND_WRITE, DEPTH + 2);
		wait_pipe_idle();
		queue_burst(KIND_READ, 300);

		// Mixed traffic of write and read requests, which takes the tail
		// index across the wrap and keeps the fill level moving.
		mixed = 0;
		while (mixed < 200) begin
			k = ($urandom_range(99) < 50) ? KIND_WRITE : KIND_READ;
			n = $urandom_range(24, 1);
			queue_burst(k, n);
			mixed += n;
		end
		wait_pipe_idle();

		// Before the writer closes, the held bytes should straddle the end of
		// the ring so that the drain after the close crosses the wrap.
		guard = 0;
		while (!(held_bytes() > 0 && ring_head > ring_tail) && guard < 64) begin
			if (held_bytes() >= DEPTH - 2)
				queue_burst(KIND_READ, 32);
			else
				queue_burst(KIND_WRITE, (DEPTH - 1 - held_bytes() < 32) ?
					DEPTH - 1 - held_bytes() : 32);
			wait_pipe_idle();
			guard++;
		end

		// Writer closes: writes fail, reads drain what is held and then
		// report end of data. A second close of the same end is harmless.
		queue_cmd(KIND_CLOSE_WR, 8'($urandom), 1'b1);
		queue_cmd(KIND_WRITE, 8'($urandom), 1'b1);
		queue_burst(KIND_READ, held_bytes());
		queue_cmd(KIND_READ, 8'($urandom), 1'b0);
		queue_cmd(KIND_READ, 8'($urandom), 1'b1);
		queue_cmd(KIND_CLOSE_WR, 8'($urandom), 1'b0);
		for (int i = 0; i < 20; i++)
			queue_cmd(op_kind_t'($urandom_range(int'(KIND_CLOSE_WR))), 8'($urandom),
				1'($urandom));

		// Reader closes too: from here on every data command fails.
		queue_cmd(KIND_CLOSE_RD, 8'($urandom), 1'b1);
		for (int i = 0; i < 30; i++)
			queue_cmd(op_kind_t'($urandom_range(int'(KIND_CLOSE_RD))), 8'($urandom),
				1'($urandom));
		wait_pipe_idle();

		if (awaited_rsp.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", awaited_rsp.size()));

		$display("Covered %0d transfers: %0d writes, %0d reads, %0d writer and %0d reader closes.",
			xfer_cnt, kind_seen[int'(KIND_WRITE)], kind_seen[int'(KIND_READ)],
			kind_seen[int'(KIND_CLOSE_WR)], kind_seen[int'(KIND_CLOSE_RD)]);
		$display("Statuses ok %0d, wait %0d, end of data %0d, closed end %0d; peak fill %0d.",
			status_seen[int'(ST_OK)], status_seen[int'(ST_WAIT)],
			status_seen[int'(ST_EOD)], status_seen[int'(ST_FAIL)], fill_peak);
		if (error_cnt == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

### sim.f
hdl/prf_pkg.sv
hdl/prf_ctrl.sv
hdl/prf_dp.sv
hdl/pipe_ring_fifo_core.sv
bench/tb.sv
